### rtl/assert_macros.svh
// Assertion macros for the segment intersection block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_RST(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

`define ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) else $error(msg);

`else

`define ASSERT_RST(lbl, clk, rstn, prop, msg)

`define ASSERT_NEVER(lbl, clk, rstn, expr, msg)

`endif

`endif

### rtl/ssi_pkg.sv
`default_nettype none

package ssi_pkg;

  localparam int unsigned TOL_W = 8;
  localparam logic [TOL_W-1:0] TOL_RESET = 8'd1;
  localparam int unsigned KIND_W = 3;

  typedef enum logic [KIND_W-1:0] {
    KIND_NONE    = 3'd0,
    KIND_B_START = 3'd1,
    KIND_B_END   = 3'd2,
    KIND_A_START = 3'd3,
    KIND_A_END   = 3'd4,
    KIND_CROSS   = 3'd5
  } hit_kind_e;

endpackage

`default_nettype wire

### rtl/ssi_queue.sv
`default_nettype none
`include "assert_macros.svh"

module ssi_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [WIDTH-1:0]      rdata_o,
  output logic                  empty_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [AW:0]      count_q, count_d;

  assign full_o  = (count_q == (AW+1)'(DEPTH));
  assign empty_o = (count_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  `ASSERT_NEVER(a_no_overflow, clk_i, rst_ni, push_i && full_o, "queue overflow")
  `ASSERT_NEVER(a_no_underflow, clk_i, rst_ni, pop_i && empty_o, "queue underflow")

endmodule

`default_nettype wire

### rtl/ssi_front.sv
`default_nettype none

module ssi_front #(
  parameter int unsigned COORD_BITS = 24
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic [ssi_pkg::TOL_W-1:0]    tol_i,
  input  wire logic                         push_i,
  output logic                              full_o,
  input  wire logic signed [COORD_BITS-1:0] a_start_x_i,
  input  wire logic signed [COORD_BITS-1:0] a_start_y_i,
  input  wire logic signed [COORD_BITS-1:0] a_end_x_i,
  input  wire logic signed [COORD_BITS-1:0] a_end_y_i,
  input  wire logic signed [COORD_BITS-1:0] b_start_x_i,
  input  wire logic signed [COORD_BITS-1:0] b_start_y_i,
  input  wire logic signed [COORD_BITS-1:0] b_end_x_i,
  input  wire logic signed [COORD_BITS-1:0] b_end_y_i,
  input  wire logic                         q_full_i,
  output logic                              q_push_o,
  output ssi_pkg::hit_kind_e                kind_o,
  output logic signed [COORD_BITS-1:0]      base_x_o,
  output logic signed [COORD_BITS-1:0]      base_y_o,
  output logic signed [COORD_BITS:0]        v1x_o,
  output logic signed [COORD_BITS:0]        v1y_o,
  output logic [2*COORD_BITS+2:0]           num_o,
  output logic [2*COORD_BITS+3:0]           den_o
);

  localparam int unsigned D  = COORD_BITS + 1;
  localparam int unsigned P  = 2 * D;
  localparam int unsigned CW = P + 1;
  localparam int unsigned TW = ssi_pkg::TOL_W;

  function automatic logic [D-1:0] mag_d(logic signed [D-1:0] v);
    return v[D-1] ? D'(-v) : D'(v);
  endfunction

  function automatic logic btw(logic signed [D-1:0] d1, logic signed [D-1:0] d2);
    logic p1, p2, n1, n2;
    p1 = !d1[D-1] && (d1 != '0);
    p2 = !d2[D-1] && (d2 != '0);
    n1 = d1[D-1];
    n2 = d2[D-1];
    return !(p1 && p2) && !(n1 && n2);
  endfunction

  logic adv, accept;

  // stage 1: differences
  logic                         s1_v_q;
  logic signed [D-1:0]          dx_d [6], dy_d [6], dx_q [6], dy_q [6];
  logic signed [COORD_BITS-1:0] ptx_d [4], pty_d [4], ptx1_q [4], pty1_q [4];

  // stage 2: products and distance flags
  logic                         s2_v_q;
  logic signed [P-1:0]          pa_d [4], pb_d [4], pa_q [4], pb_q [4];
  logic [5:0]                   near;
  logic [3:0]                   pn_d, pn2_q, bb_d, bb2_q;
  logic                         long_d, long2_q;
  logic signed [COORD_BITS-1:0] ptx2_q [4], pty2_q [4];
  logic signed [D-1:0]          v1x2_q, v1y2_q;

  // stage 3: cross products
  logic                         s3_v_q;
  logic signed [CW-1:0]         c_q [4];
  logic [3:0]                   pn3_q, bb3_q;
  logic                         long3_q;
  logic signed [COORD_BITS-1:0] ptx3_q [4], pty3_q [4];
  logic signed [D-1:0]          v1x3_q, v1y3_q;

  logic [CW-1:0]                mag [4];
  logic [3:0]                   gt, on;
  logic [2*TW-1:0]              sp_a, sp_b;
  logic                         st_a, st_b;

  assign adv      = !s3_v_q || !q_full_i;
  assign full_o   = !adv;
  assign accept   = push_i && adv;
  assign q_push_o = s3_v_q && !q_full_i;

  always_comb begin
    dx_d[0] = D'(b_start_x_i) - D'(a_start_x_i);
    dy_d[0] = D'(b_start_y_i) - D'(a_start_y_i);
    dx_d[1] = D'(b_end_x_i) - D'(a_start_x_i);
    dy_d[1] = D'(b_end_y_i) - D'(a_start_y_i);
    dx_d[2] = D'(b_start_x_i) - D'(a_end_x_i);
    dy_d[2] = D'(b_start_y_i) - D'(a_end_y_i);
    dx_d[3] = D'(b_end_x_i) - D'(a_end_x_i);
    dy_d[3] = D'(b_end_y_i) - D'(a_end_y_i);
    dx_d[4] = D'(a_end_x_i) - D'(a_start_x_i);
    dy_d[4] = D'(a_end_y_i) - D'(a_start_y_i);
    dx_d[5] = D'(b_end_x_i) - D'(b_start_x_i);
    dy_d[5] = D'(b_end_y_i) - D'(b_start_y_i);
    ptx_d[0] = b_start_x_i;
    pty_d[0] = b_start_y_i;
    ptx_d[1] = b_end_x_i;
    pty_d[1] = b_end_y_i;
    ptx_d[2] = a_start_x_i;
    pty_d[2] = a_start_y_i;
    ptx_d[3] = a_end_x_i;
    pty_d[3] = a_end_y_i;
  end

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      near[k] = ((D+1)'(mag_d(dx_q[k])) + (D+1)'(mag_d(dy_q[k]))) < (D+1)'(tol_i);
    end
    pn_d[0] = near[0] || near[2];
    pn_d[1] = near[1] || near[3];
    pn_d[2] = near[0] || near[1];
    pn_d[3] = near[2] || near[3];
    long_d  = !near[4] && !near[5];
    bb_d[0] = btw(dx_q[0], dx_q[2]) && btw(dy_q[0], dy_q[2]);
    bb_d[1] = btw(dx_q[1], dx_q[3]) && btw(dy_q[1], dy_q[3]);
    bb_d[2] = btw(dx_q[0], dx_q[1]) && btw(dy_q[0], dy_q[1]);
    bb_d[3] = btw(dx_q[2], dx_q[3]) && btw(dy_q[2], dy_q[3]);
    pa_d[0] = P'(dx_q[4]) * P'(dy_q[0]);
    pb_d[0] = P'(dy_q[4]) * P'(dx_q[0]);
    pa_d[1] = P'(dx_q[4]) * P'(dy_q[1]);
    pb_d[1] = P'(dy_q[4]) * P'(dx_q[1]);
    pa_d[2] = P'(dx_q[5]) * P'(dy_q[0]);
    pb_d[2] = P'(dy_q[5]) * P'(dx_q[0]);
    pa_d[3] = P'(dx_q[5]) * P'(dy_q[2]);
    pb_d[3] = P'(dy_q[5]) * P'(dx_q[2]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
    end else if (adv) begin
      s1_v_q <= accept;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dx_q    <= dx_d;
      dy_q    <= dy_d;
      ptx1_q  <= ptx_d;
      pty1_q  <= pty_d;
      pa_q    <= pa_d;
      pb_q    <= pb_d;
      pn2_q   <= pn_d;
      bb2_q   <= bb_d;
      long2_q <= long_d;
      ptx2_q  <= ptx1_q;
      pty2_q  <= pty1_q;
      v1x2_q  <= dx_q[4];
      v1y2_q  <= dy_q[4];
      for (int k = 0; k < 4; k++) begin
        c_q[k] <= CW'(pa_q[k]) - CW'(pb_q[k]);
      end
      pn3_q   <= pn2_q;
      bb3_q   <= bb2_q;
      long3_q <= long2_q;
      ptx3_q  <= ptx2_q;
      pty3_q  <= pty2_q;
      v1x3_q  <= v1x2_q;
      v1y3_q  <= v1y2_q;
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      mag[k] = c_q[k][CW-1] ? CW'(-c_q[k]) : CW'(c_q[k]);
      gt[k]  = mag[k] > CW'(tol_i);
      on[k]  = pn3_q[k] || (!gt[k] && bb3_q[k]);
    end
    sp_a = mag[0][TW-1:0] * mag[1][TW-1:0];
    sp_b = mag[2][TW-1:0] * mag[3][TW-1:0];
    st_a = (c_q[0] != '0) && (c_q[1] != '0) && (c_q[0][CW-1] != c_q[1][CW-1])
           && (gt[0] || gt[1] || (sp_a > (2*TW)'(tol_i)));
    st_b = (c_q[2] != '0) && (c_q[3] != '0) && (c_q[2][CW-1] != c_q[3][CW-1])
           && (gt[2] || gt[3] || (sp_b > (2*TW)'(tol_i)));
    kind_o   = ssi_pkg::KIND_NONE;
    base_x_o = '0;
    base_y_o = '0;
    if (on[0]) begin
      kind_o   = ssi_pkg::KIND_B_START;
      base_x_o = ptx3_q[0];
      base_y_o = pty3_q[0];
    end else if (on[1]) begin
      kind_o   = ssi_pkg::KIND_B_END;
      base_x_o = ptx3_q[1];
      base_y_o = pty3_q[1];
    end else if (on[2]) begin
      kind_o   = ssi_pkg::KIND_A_START;
      base_x_o = ptx3_q[2];
      base_y_o = pty3_q[2];
    end else if (on[3]) begin
      kind_o   = ssi_pkg::KIND_A_END;
      base_x_o = ptx3_q[3];
      base_y_o = pty3_q[3];
    end else if (long3_q && st_a && st_b) begin
      kind_o   = ssi_pkg::KIND_CROSS;
      base_x_o = ptx3_q[2];
      base_y_o = pty3_q[2];
    end
    v1x_o = v1x3_q;
    v1y_o = v1y3_q;
    num_o = mag[2];
    den_o = (CW+1)'(mag[2]) + (CW+1)'(mag[3]);
  end

endmodule

`default_nettype wire

### rtl/ssi_back.sv
`default_nettype none

module ssi_back #(
  parameter int unsigned COORD_BITS = 24
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          q_empty_i,
  output logic                               q_pop_o,
  input  wire logic [ssi_pkg::KIND_W-1:0]    kind_i,
  input  wire logic signed [COORD_BITS-1:0]  base_x_i,
  input  wire logic signed [COORD_BITS-1:0]  base_y_i,
  input  wire logic signed [COORD_BITS:0]    v1x_i,
  input  wire logic signed [COORD_BITS:0]    v1y_i,
  input  wire logic [2*COORD_BITS+2:0]       num_i,
  input  wire logic [2*COORD_BITS+3:0]       den_i,
  input  wire logic                          pop_i,
  output logic                               empty_o,
  output logic [ssi_pkg::KIND_W-1:0]         kind_o,
  output logic signed [COORD_BITS-1:0]       px_o,
  output logic signed [COORD_BITS-1:0]       py_o
);

  localparam int unsigned D  = COORD_BITS + 1;
  localparam int unsigned CW = 2 * D + 1;
  localparam int unsigned RW = CW + 1;
  localparam int unsigned T  = RW + 2;

  function automatic logic [RW+D-1:0] dstep(logic [RW-1:0] r, logic [D-1:0] q, logic b,
                                            logic [CW-1:0] num, logic [RW-1:0] den);
    logic [T-1:0]  t, d1, d2;
    logic [RW-1:0] rn;
    logic [D-1:0]  qn;
    t  = (T'(r) << 1) + (b ? T'(num) : '0);
    d1 = T'(den);
    d2 = d1 << 1;
    if (t >= d2) begin
      rn = RW'(t - d2);
      qn = (q << 1) + D'(2);
    end else if (t >= d1) begin
      rn = RW'(t - d1);
      qn = (q << 1) + D'(1);
    end else begin
      rn = RW'(t);
      qn = q << 1;
    end
    return {rn, qn};
  endfunction

  logic                         sv_q    [D+1];
  logic [ssi_pkg::KIND_W-1:0]   kind_q  [D+1];
  logic signed [COORD_BITS-1:0] bx_q    [D+1], by_q [D+1];
  logic [D-1:0]                 mx_q    [D+1], my_q [D+1];
  logic                         nx_q    [D+1], ny_q [D+1];
  logic [CW-1:0]                num_q   [D+1];
  logic [RW-1:0]                den_q   [D+1];
  logic [RW-1:0]                rx_q    [D+1], ry_q [D+1];
  logic [D-1:0]                 qx_q    [D+1], qy_q [D+1];

  logic adv, out_free, out_v_q;
  logic [D-1:0] offx, offy;

  assign out_free = !out_v_q || pop_i;
  assign adv      = !sv_q[D] || out_free;
  assign q_pop_o  = adv && !q_empty_i;
  assign empty_o  = !out_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j <= D; j++) begin
        sv_q[j] <= 1'b0;
      end
    end else if (adv) begin
      sv_q[0] <= !q_empty_i;
      for (int j = 0; j < D; j++) begin
        sv_q[j+1] <= sv_q[j];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      kind_q[0] <= kind_i;
      bx_q[0]   <= base_x_i;
      by_q[0]   <= base_y_i;
      mx_q[0]   <= v1x_i[D-1] ? D'(-v1x_i) : D'(v1x_i);
      my_q[0]   <= v1y_i[D-1] ? D'(-v1y_i) : D'(v1y_i);
      nx_q[0]   <= v1x_i[D-1];
      ny_q[0]   <= v1y_i[D-1];
      num_q[0]  <= num_i;
      den_q[0]  <= den_i;
      rx_q[0]   <= '0;
      ry_q[0]   <= '0;
      qx_q[0]   <= '0;
      qy_q[0]   <= '0;
    end
  end

  for (genvar j = 0; j < D; j++) begin : g_step
    logic [RW+D-1:0] sx, sy;
    assign sx = dstep(rx_q[j], qx_q[j], mx_q[j][D-1-j], num_q[j], den_q[j]);
    assign sy = dstep(ry_q[j], qy_q[j], my_q[j][D-1-j], num_q[j], den_q[j]);
    always_ff @(posedge clk_i) begin
      if (adv) begin
        kind_q[j+1] <= kind_q[j];
        bx_q[j+1]   <= bx_q[j];
        by_q[j+1]   <= by_q[j];
        mx_q[j+1]   <= mx_q[j];
        my_q[j+1]   <= my_q[j];
        nx_q[j+1]   <= nx_q[j];
        ny_q[j+1]   <= ny_q[j];
        num_q[j+1]  <= num_q[j];
        den_q[j+1]  <= den_q[j];
        rx_q[j+1]   <= sx[RW+D-1:D];
        ry_q[j+1]   <= sy[RW+D-1:D];
        qx_q[j+1]   <= sx[D-1:0];
        qy_q[j+1]   <= sy[D-1:0];
      end
    end
  end

  assign offx = (kind_q[D] != ssi_pkg::KIND_CROSS) ? '0 :
                (nx_q[D] ? D'(-qx_q[D]) : qx_q[D]);
  assign offy = (kind_q[D] != ssi_pkg::KIND_CROSS) ? '0 :
                (ny_q[D] ? D'(-qy_q[D]) : qy_q[D]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (sv_q[D] && out_free) begin
      out_v_q <= 1'b1;
    end else if (pop_i) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sv_q[D] && out_free) begin
      kind_o <= kind_q[D];
      px_o   <= COORD_BITS'(D'(bx_q[D]) + offx);
      py_o   <= COORD_BITS'(D'(by_q[D]) + offy);
    end
  end

endmodule

`default_nettype wire

### rtl/segment_segment_intersection_core.sv
// Throughput: one beat per cycle while not stalled by back-pressure; a three-stage classifier,
// a four-entry queue and a COORD_BITS+1 stage radix-2 divider pipeline each take one beat a cycle.
// Reset: asynchronous, active low; empties all stages and sets tolerance to 1.
`default_nettype none
`include "assert_macros.svh"

module segment_segment_intersection_core #(
  parameter int unsigned COORD_BITS = 24
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         tolerance_we_i,
  input  wire logic [ssi_pkg::TOL_W-1:0]    tolerance_i,
  input  wire logic                         push,
  output logic                              full,
  input  wire logic signed [COORD_BITS-1:0] a_start_x_i,
  input  wire logic signed [COORD_BITS-1:0] a_start_y_i,
  input  wire logic signed [COORD_BITS-1:0] a_end_x_i,
  input  wire logic signed [COORD_BITS-1:0] a_end_y_i,
  input  wire logic signed [COORD_BITS-1:0] b_start_x_i,
  input  wire logic signed [COORD_BITS-1:0] b_start_y_i,
  input  wire logic signed [COORD_BITS-1:0] b_end_x_i,
  input  wire logic signed [COORD_BITS-1:0] b_end_y_i,
  output logic                              empty,
  input  wire logic                         pop,
  output logic [ssi_pkg::KIND_W-1:0]        hit_kind_o,
  output logic signed [COORD_BITS-1:0]      point_x_o,
  output logic signed [COORD_BITS-1:0]      point_y_o
);

  localparam int unsigned D  = COORD_BITS + 1;
  localparam int unsigned CW = 2 * D + 1;
  localparam int unsigned QW = ssi_pkg::KIND_W + 2 * COORD_BITS + 2 * D + 2 * CW + 1;

  logic [ssi_pkg::TOL_W-1:0] tol_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= ssi_pkg::TOL_RESET;
    end else if (tolerance_we_i) begin
      tol_q <= tolerance_i;
    end
  end

  ssi_pkg::hit_kind_e           f_kind;
  logic signed [COORD_BITS-1:0] f_bx, f_by, b_bx, b_by;
  logic signed [D-1:0]          f_v1x, f_v1y, b_v1x, b_v1y;
  logic [CW-1:0]                f_num, b_num;
  logic [CW:0]                  f_den, b_den;
  logic [ssi_pkg::KIND_W-1:0]   b_kind;
  logic                         q_push, q_full, q_pop, q_empty;
  logic [QW-1:0]                q_wdata, q_rdata;

  ssi_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tol_i       (tol_q),
    .push_i      (push),
    .full_o      (full),
    .a_start_x_i (a_start_x_i),
    .a_start_y_i (a_start_y_i),
    .a_end_x_i   (a_end_x_i),
    .a_end_y_i   (a_end_y_i),
    .b_start_x_i (b_start_x_i),
    .b_start_y_i (b_start_y_i),
    .b_end_x_i   (b_end_x_i),
    .b_end_y_i   (b_end_y_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .kind_o      (f_kind),
    .base_x_o    (f_bx),
    .base_y_o    (f_by),
    .v1x_o       (f_v1x),
    .v1y_o       (f_v1y),
    .num_o       (f_num),
    .den_o       (f_den)
  );

  assign q_wdata = {f_kind, f_bx, f_by, f_v1x, f_v1y, f_num, f_den};

  ssi_queue #(.WIDTH(QW), .DEPTH(4)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .rdata_o (q_rdata),
    .empty_o (q_empty)
  );

  assign {b_kind, b_bx, b_by, b_v1x, b_v1y, b_num, b_den} = q_rdata;

  ssi_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_pop_o   (q_pop),
    .kind_i    (b_kind),
    .base_x_i  (b_bx),
    .base_y_i  (b_by),
    .v1x_i     (b_v1x),
    .v1y_i     (b_v1y),
    .num_i     (b_num),
    .den_i     (b_den),
    .pop_i     (pop),
    .empty_o   (empty),
    .kind_o    (hit_kind_o),
    .px_o      (point_x_o),
    .py_o      (point_y_o)
  );

  `ASSERT_RST(a_kind_range, clk_i, rst_ni, !empty |-> (hit_kind_o <= ssi_pkg::KIND_CROSS), "bad hit kind")
  `ASSERT_RST(a_none_zero, clk_i, rst_ni, (!empty && hit_kind_o == ssi_pkg::KIND_NONE) |-> (point_x_o == '0 && point_y_o == '0), "miss with nonzero point")

endmodule

`default_nettype wire
